@@ design/bps_pkg.sv @@
// Shared types, field widths and constants for the bucketed pair sampler.
package bps_pkg;

    localparam int MAX_BUCKETS_DEF    = 256;
    localparam int MAX_PER_BUCKET_DEF = 64;
    localparam int INDEX_BITS_DEF     = 32;

    localparam int DIST_W   = 17;
    localparam int BSEL_W   = 9;
    localparam int SSEL_W   = 6;
    localparam int IDX_W    = 32;
    localparam int FILL_W   = 7;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIST_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [8:0] BUCKET_COUNT_RST = 9'd256;
    localparam logic [6:0] CAP_RST          = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUCKET_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP          = 1'b1;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

endpackage

@@ design/bps_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bps_ctrl.sv @@
// Transaction controller: input acceptance, commit sequencing and output valid.
module bps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bps_pkg::t_cmd o_cmd
);

    bps_pkg::t_state r_state;
    bps_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_state)
            bps_pkg::S_IDLE: begin
                n_state = i_in_valid ? bps_pkg::S_EXEC : bps_pkg::S_IDLE;
            end
            bps_pkg::S_EXEC: begin
                n_state = w_out_free ? bps_pkg::S_IDLE : bps_pkg::S_EXEC;
            end
            default: begin
                n_state = bps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            bps_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bps_pkg::S_EXEC: begin
                o_cmd.commit = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bps_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/bps_datapath.sv @@
// Datapath: bucket mapping, fill counts, pair store and result registers.
module bps_datapath #(
    parameter int MAX_BUCKETS    = bps_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_PER_BUCKET = bps_pkg::MAX_PER_BUCKET_DEF,
    parameter int INDEX_BITS     = bps_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bps_pkg::t_cmd                   i_cmd,
    input  logic                            i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_operation,
    input  logic [bps_pkg::DIST_W-1:0]      i_distance,
    input  logic [bps_pkg::IDX_W-1:0]       i_row_index,
    input  logic [bps_pkg::IDX_W-1:0]       i_col_index,
    input  logic [bps_pkg::BSEL_W-1:0]      i_bucket_select,
    input  logic [bps_pkg::SSEL_W-1:0]      i_slot_select,
    output logic                            o_accepted,
    output logic [bps_pkg::BSEL_W-1:0]      o_bucket_index,
    output logic [bps_pkg::SSEL_W-1:0]      o_slot_index,
    output logic                            o_bucket_filled,
    output logic                            o_all_filled,
    output logic [bps_pkg::IDX_W-1:0]       o_stored_row,
    output logic [bps_pkg::IDX_W-1:0]       o_stored_col,
    output logic [bps_pkg::FILL_W-1:0]      o_bucket_fill
);

    localparam int TOTAL = MAX_BUCKETS + 2;
    localparam int BW    = $clog2(TOTAL);
    localparam int SW    = (MAX_PER_BUCKET > 1) ? $clog2(MAX_PER_BUCKET) : 1;
    localparam int FW    = $clog2(MAX_PER_BUCKET + 1);
    localparam int DEPTH = TOTAL * MAX_PER_BUCKET;
    localparam int AW    = $clog2(DEPTH);
    localparam int NBW   = $clog2(MAX_BUCKETS + 1);
    localparam int UW    = $clog2(MAX_BUCKETS + 3);
    localparam int PW    = bps_pkg::DIST_W + NBW;

    function automatic logic [NBW-1:0] f_eff_nb(input logic [8:0] v);
        logic [NBW-1:0] res;
        if (v == 9'd0) begin
            res = NBW'(1);
        end else if (32'(v) > MAX_BUCKETS) begin
            res = NBW'(MAX_BUCKETS);
        end else begin
            res = NBW'(v);
        end
        return res;
    endfunction

    function automatic logic [FW-1:0] f_eff_cap(input logic [6:0] v);
        logic [FW-1:0] res;
        if (v == 7'd0) begin
            res = FW'(1);
        end else if (32'(v) > MAX_PER_BUCKET) begin
            res = FW'(MAX_PER_BUCKET);
        end else begin
            res = FW'(v);
        end
        return res;
    endfunction

    logic [8:0]            r_bucket_count;
    logic [6:0]            r_cap;
    logic [UW-1:0]         r_unfilled;
    logic [UW-1:0]         n_unfilled;
    logic                  r_done;
    logic                  n_done;
    logic                  r_fill_vld [TOTAL];

    logic [NBW-1:0]        w_nb;
    logic [FW-1:0]         w_cap;
    logic [NBW-1:0]        w_cfg_nb;

    logic [bps_pkg::DIST_W-1:0] w_dist;
    logic [PW-1:0]         w_prod;
    logic [BW-1:0]         w_offer_bucket;
    logic [BW-1:0]         w_load_bucket;
    logic [AW-1:0]         w_pair_raddr;
    logic                  w_rd_in_range;

    logic                  r_op;
    logic [BW-1:0]         r_bucket;
    logic [bps_pkg::BSEL_W-1:0] r_bucket_out;
    logic [bps_pkg::SSEL_W-1:0] r_ssel;
    logic                  r_in_range;
    logic [INDEX_BITS-1:0] r_row;
    logic [INDEX_BITS-1:0] r_col;

    logic [FW-1:0]         w_fill_rdata;
    logic [2*INDEX_BITS-1:0] w_pair_rdata;
    logic                  w_vld;
    logic [FW-1:0]         w_fill_cur;
    logic [FW-1:0]         w_fill_new;
    logic                  w_take;
    logic                  w_filled;
    logic                  w_slot_hit;
    logic [AW-1:0]         w_pair_waddr;

    logic                  r_accepted;
    logic [bps_pkg::BSEL_W-1:0] r_bucket_index;
    logic [bps_pkg::SSEL_W-1:0] r_slot_index;
    logic                  r_bucket_filled;
    logic                  r_all_filled;
    logic [bps_pkg::IDX_W-1:0] r_stored_row;
    logic [bps_pkg::IDX_W-1:0] r_stored_col;
    logic [bps_pkg::FILL_W-1:0] r_bucket_fill;

    assign w_nb  = f_eff_nb(r_bucket_count);
    assign w_cap = f_eff_cap(r_cap);
    assign w_cfg_nb = (i_cfg_index == bps_pkg::CFG_IDX_BUCKET_COUNT)
                    ? f_eff_nb(i_cfg_data[8:0]) : w_nb;

    // Map distance to bucket; saturate above one.
    assign w_dist = (i_distance > bps_pkg::ONE_Q16) ? bps_pkg::ONE_Q16 : i_distance;
    assign w_prod = PW'(w_dist) * PW'(w_nb);

    always_comb begin
        if (w_dist == '0) begin
            w_offer_bucket = '0;
        end else if (w_dist == bps_pkg::ONE_Q16) begin
            w_offer_bucket = BW'(w_nb) + BW'(1);
        end else begin
            w_offer_bucket = BW'(w_prod[PW-1:16]) + BW'(1);
        end
    end

    assign w_rd_in_range = 32'(i_bucket_select) <= (32'(w_nb) + 32'd1);
    assign w_load_bucket = (i_operation == bps_pkg::OP_OFFER)
                         ? w_offer_bucket : BW'(i_bucket_select);
    assign w_pair_raddr  = AW'(BW'(i_bucket_select)) * AW'(MAX_PER_BUCKET)
                         + AW'(i_slot_select);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_operation;
            r_bucket     <= w_load_bucket;
            r_bucket_out <= (i_operation == bps_pkg::OP_OFFER)
                          ? bps_pkg::BSEL_W'(w_offer_bucket) : i_bucket_select;
            r_ssel       <= i_slot_select;
            r_in_range   <= (i_operation == bps_pkg::OP_OFFER) || w_rd_in_range;
            r_row        <= i_row_index[INDEX_BITS-1:0];
            r_col        <= i_col_index[INDEX_BITS-1:0];
        end
    end

    bps_ram #(
        .WIDTH (FW),
        .DEPTH (TOTAL)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_take),
        .i_waddr (r_bucket),
        .i_wdata (w_fill_new),
        .i_re    (i_cmd.load),
        .i_raddr (w_load_bucket),
        .o_rdata (w_fill_rdata)
    );

    bps_ram #(
        .WIDTH (2 * INDEX_BITS),
        .DEPTH (DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_take),
        .i_waddr (w_pair_waddr),
        .i_wdata ({r_col, r_row}),
        .i_re    (i_cmd.load),
        .i_raddr (w_pair_raddr),
        .o_rdata (w_pair_rdata)
    );

    assign w_vld      = r_in_range && r_fill_vld[r_bucket];
    assign w_fill_cur = w_vld ? w_fill_rdata : '0;
    assign w_fill_new = w_fill_cur + FW'(1);
    assign w_take     = (r_op == bps_pkg::OP_OFFER) && !r_done && (w_fill_cur < w_cap);
    assign w_filled   = w_take && (w_fill_new == w_cap);
    assign w_slot_hit = (r_op == bps_pkg::OP_READ) && r_in_range
                      && (32'(r_ssel) < 32'(w_fill_cur));
    assign w_pair_waddr = AW'(r_bucket) * AW'(MAX_PER_BUCKET) + AW'(SW'(w_fill_cur));

    always_comb begin
        n_unfilled = r_unfilled;
        n_done     = r_done;
        if (w_filled) begin
            if (r_unfilled != '0) begin
                n_unfilled = r_unfilled - UW'(1);
            end
            if (n_unfilled == '0) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= bps_pkg::BUCKET_COUNT_RST;
            r_cap          <= bps_pkg::CAP_RST;
            r_unfilled     <= UW'(f_eff_nb(bps_pkg::BUCKET_COUNT_RST)) + UW'(2);
            r_done         <= 1'b0;
            for (int i = 0; i < TOTAL; i++) begin
                r_fill_vld[i] <= 1'b0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bps_pkg::CFG_IDX_BUCKET_COUNT: r_bucket_count <= i_cfg_data[8:0];
                bps_pkg::CFG_IDX_CAP:          r_cap          <= i_cfg_data[6:0];
                default:                       r_cap          <= r_cap;
            endcase
            r_unfilled <= UW'(w_cfg_nb) + UW'(2);
            r_done     <= 1'b0;
            for (int i = 0; i < TOTAL; i++) begin
                r_fill_vld[i] <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            r_unfilled <= n_unfilled;
            r_done     <= n_done;
            if (w_take) begin
                r_fill_vld[r_bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_accepted      <= w_take;
            r_bucket_index  <= r_bucket_out;
            r_bucket_filled <= w_filled;
            r_all_filled    <= n_done;
            if (r_op == bps_pkg::OP_OFFER) begin
                r_slot_index  <= w_take ? bps_pkg::SSEL_W'(w_fill_cur) : '0;
                r_bucket_fill <= bps_pkg::FILL_W'(w_take ? w_fill_new : w_fill_cur);
            end else begin
                r_slot_index  <= r_ssel;
                r_bucket_fill <= bps_pkg::FILL_W'(w_fill_cur);
            end
            if (w_slot_hit) begin
                r_stored_row <= bps_pkg::IDX_W'(w_pair_rdata[INDEX_BITS-1:0]);
                r_stored_col <= bps_pkg::IDX_W'(w_pair_rdata[2*INDEX_BITS-1:INDEX_BITS]);
            end else begin
                r_stored_row <= '0;
                r_stored_col <= '0;
            end
        end
    end

    assign o_accepted      = r_accepted;
    assign o_bucket_index  = r_bucket_index;
    assign o_slot_index    = r_slot_index;
    assign o_bucket_filled = r_bucket_filled;
    assign o_all_filled    = r_all_filled;
    assign o_stored_row    = r_stored_row;
    assign o_stored_col    = r_stored_col;
    assign o_bucket_fill   = r_bucket_fill;

endmodule

@@ design/bucketed_pair_sampler_top.sv @@
// Top level of the bucketed pair sampler: controller and datapath.
//
//   channel  handshake                   payload
//   in       i_in_valid / o_in_ready     i_operation, i_distance, i_row_index,
//                                        i_col_index, i_bucket_select, i_slot_select
//   out      o_out_valid / i_out_ready   o_accepted ... o_bucket_fill
//   cfg      i_cfg_we                    i_cfg_index, i_cfg_data
//
// Per transaction, the accept cycle issues the fill-count RAM read, and the EXEC
// state then commits the count and pair writes and loads the output register.
// The output register lets a new transaction be accepted while a result waits;
// commit holds while the previous result is still pending.
// Reset and any cfg write clear per-bucket valid bits at once; no clearing pass.
module bucketed_pair_sampler_top #(
    parameter int MAX_BUCKETS    = bps_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_PER_BUCKET = bps_pkg::MAX_PER_BUCKET_DEF,
    parameter int INDEX_BITS     = bps_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic [bps_pkg::DIST_W-1:0]      i_distance,
    input  logic [bps_pkg::IDX_W-1:0]       i_row_index,
    input  logic [bps_pkg::IDX_W-1:0]       i_col_index,
    input  logic [bps_pkg::BSEL_W-1:0]      i_bucket_select,
    input  logic [bps_pkg::SSEL_W-1:0]      i_slot_select,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted,
    output logic [bps_pkg::BSEL_W-1:0]      o_bucket_index,
    output logic [bps_pkg::SSEL_W-1:0]      o_slot_index,
    output logic                            o_bucket_filled,
    output logic                            o_all_filled,
    output logic [bps_pkg::IDX_W-1:0]       o_stored_row,
    output logic [bps_pkg::IDX_W-1:0]       o_stored_col,
    output logic [bps_pkg::FILL_W-1:0]      o_bucket_fill,
    input  logic                            i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]       i_cfg_data
);

    bps_pkg::t_cmd w_cmd;

    bps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    bps_datapath #(
        .MAX_BUCKETS    (MAX_BUCKETS),
        .MAX_PER_BUCKET (MAX_PER_BUCKET),
        .INDEX_BITS     (INDEX_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_distance      (i_distance),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_bucket_select (i_bucket_select),
        .i_slot_select   (i_slot_select),
        .o_accepted      (o_accepted),
        .o_bucket_index  (o_bucket_index),
        .o_slot_index    (o_slot_index),
        .o_bucket_filled (o_bucket_filled),
        .o_all_filled    (o_all_filled),
        .o_stored_row    (o_stored_row),
        .o_stored_col    (o_stored_col),
        .o_bucket_fill   (o_bucket_fill)
    );

endmodule
